// ----- rtl/linear_interp_audio_resampler_defines.svh -----
// Assertion macros shared by the resampler RTL.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH
`define LINEAR_INTERP_AUDIO_RESAMPLER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define LIR_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, ignored while reset is held.
`define LIR_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ----- rtl/lir_pkg.sv -----
// Package for the linear-interpolation resampler: constants, codes and types.
// No dependencies; used by lir_lane and linear_interp_audio_resampler.
package lir_pkg;

  // Widths
  localparam int DATA_W              = 32;
  localparam int APB_ADDR_W          = 5;
  localparam int STEP_W              = 21;
  localparam int STEP_FRAC_BITS      = 16;
  localparam int PHASE_FRAC_BITS_DEF = 16;

  // Step register: reset value and floor
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(65536);
  localparam logic [STEP_W-1:0] STEP_MIN   = STEP_W'(4096);

  // Float32 exponent landmarks for Q8.24 conversion
  localparam logic [7:0] F_EXP_UNIT     = 8'd126;  // shift of zero
  localparam logic [7:0] F_EXP_SAT      = 8'd134;  // |x| >= 128 saturates
  localparam logic [7:0] F_EXP_FLUSH    = 8'd102;  // below this, all bits shift out
  localparam logic [7:0] F_EXP_BIAS_OUT = 8'd103;  // MSB position to biased exponent
  localparam logic [4:0] DEC_MAX_SHIFT  = 5'd24;

  // Q8.24 full scale
  localparam logic [DATA_W-1:0] Q_ONE   = 32'h0100_0000;
  localparam logic [DATA_W-1:0] Q_POS_SAT = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] Q_NEG_SAT = 32'h8000_0000;

  // Source sample coding
  typedef enum logic [1:0] {
    FMT_INT16 = 2'd0,
    FMT_INT24 = 2'd1,
    FMT_INT32 = 2'd2,
    FMT_F32   = 2'd3
  } lir_fmt_t;

  // Register indexes (word address)
  typedef enum logic [2:0] {
    REG_STEP    = 3'd0,
    REG_IN_FMT  = 3'd1,
    REG_SRC_ST  = 3'd2,
    REG_OUT_FLT = 3'd3,
    REG_DST_ST  = 3'd4
  } lir_reg_t;

  // Settings a channel lane needs
  typedef struct packed {
    lir_fmt_t input_format;
    logic     output_float;
  } lir_cfg_t;

  // Commands from the sequencer to the lanes
  typedef struct packed {
    logic dec;     // decode raw into the current sample
    logic emit;    // interpolate at frac and encode
    logic commit;  // current sample becomes previous
  } lir_cmd_t;

endpackage

// ----- rtl/linear_interp_audio_resampler.sv -----
// Linear-interpolation sample-rate converter, one source frame per input word.
// Decode: direct for integer formats and float32 specials, serial align shift for other float32.
// Each output word: bit-serial multiply for int16 output, plus a serial normalize for
// float32 output, plus out stalls.
// One frame at a time; the next is taken in the cycle after its last word or its decode.
// Sync active-low reset: defaults, no previous frame, phase 0. Needs lir_pkg, lir_lane.
`include "linear_interp_audio_resampler_defines.svh"

module linear_interp_audio_resampler
  import lir_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // source frames
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [DATA_W-1:0]     in_left_raw,
  input  logic [DATA_W-1:0]     in_right_raw,
  // output frames
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_W-1:0]     out_left_out,
  output logic [DATA_W-1:0]     out_right_out,
  output logic                  out_last_of_run,
  // register port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  // phase holds up to 33.0 transiently, so six integer bits
  localparam int PH_W = PHASE_FRAC_BITS + 6;
  localparam logic [PH_W-1:0] PH_ONE = PH_W'(1) << PHASE_FRAC_BITS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DEC  = 4'b0010,
    S_EMIT = 4'b0100,
    S_OUT  = 4'b1000
  } seq_st_t;

  seq_st_t           st_r, st_nxt;
  logic [PH_W-1:0]   phase_r, phase_nxt;
  logic              primed_r, primed_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  lir_fmt_t          fmt_r, fmt_nxt;
  logic              src_st_r, src_st_nxt;
  logic              out_flt_r, out_flt_nxt;
  logic              dst_st_r, dst_st_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_left_r, out_left_nxt;
  logic [DATA_W-1:0] out_right_r, out_right_nxt;
  logic              out_last_r, out_last_nxt;

  lir_cmd_t          lane_cmd;
  lir_cfg_t          lane_cfg;
  logic              l_busy, r_busy;
  logic [DATA_W-1:0] l_res, r_res;
  logic [DATA_W-1:0] r_raw;
  logic              out_load;
  logic              cfg_wr;

  // Effective step in phase units
  logic [STEP_W-1:0] step_clamped;
  logic [PH_W-1:0]   step_ph;
  logic [PH_W-1:0]   phase_sum;
  logic              sum_ge_one;
  logic              phase_ge_one;

  assign step_clamped = (step_r < STEP_MIN) ? STEP_MIN : step_r;

  generate
    if (PHASE_FRAC_BITS >= STEP_FRAC_BITS) begin : g_step_up
      assign step_ph = PH_W'(step_clamped) << (PHASE_FRAC_BITS - STEP_FRAC_BITS);
    end else begin : g_step_dn
      assign step_ph = PH_W'(step_clamped >> (STEP_FRAC_BITS - PHASE_FRAC_BITS));
    end
  endgenerate

  assign phase_sum    = phase_r + step_ph;
  assign sum_ge_one   = (phase_sum[PH_W-1:PHASE_FRAC_BITS] != '0);
  assign phase_ge_one = (phase_r[PH_W-1:PHASE_FRAC_BITS] != '0);

  // Channel lanes; a mono source decodes the left word on both
  assign lane_cfg.input_format = fmt_r;
  assign lane_cfg.output_float = out_flt_r;
  assign r_raw = src_st_r ? in_right_raw : in_left_raw;

  lir_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_l (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (lane_cfg),
    .cmd   (lane_cmd),
    .raw   (in_left_raw),
    .frac  (phase_nxt[PHASE_FRAC_BITS-1:0]),
    .busy  (l_busy),
    .res   (l_res)
  );

  lir_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_r (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (lane_cfg),
    .cmd   (lane_cmd),
    .raw   (r_raw),
    .frac  (phase_nxt[PHASE_FRAC_BITS-1:0]),
    .busy  (r_busy),
    .res   (r_res)
  );

  // Frame sequencer and phase accumulator
  always_comb begin
    st_nxt          = st_r;
    phase_nxt       = phase_r;
    primed_nxt      = primed_r;
    lane_cmd        = '0;
    out_load        = 1'b0;
    in_ready        = 1'b0;
    case (st_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          lane_cmd.dec = 1'b1;
          st_nxt       = S_DEC;
        end
      end
      S_DEC: begin
        if (!l_busy && !r_busy) begin
          if (!primed_r) begin
            // first frame only primes the history
            lane_cmd.commit = 1'b1;
            primed_nxt      = 1'b1;
            st_nxt          = S_IDLE;
          end else if (phase_ge_one) begin
            // no output position inside this interval
            phase_nxt       = phase_r - PH_ONE;
            lane_cmd.commit = 1'b1;
            st_nxt          = S_IDLE;
          end else begin
            lane_cmd.emit = 1'b1;
            st_nxt        = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (!l_busy && !r_busy) begin
          st_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (sum_ge_one) begin
            phase_nxt       = phase_sum - PH_ONE;
            lane_cmd.commit = 1'b1;
            st_nxt          = S_IDLE;
          end else begin
            phase_nxt     = phase_sum;
            lane_cmd.emit = 1'b1;
            st_nxt        = S_EMIT;
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_left_nxt  = out_left_r;
    out_right_nxt = out_right_r;
    out_last_nxt  = out_last_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_left_nxt  = l_res;
      out_right_nxt = dst_st_r ? r_res : '0;
      out_last_nxt  = sum_ge_one;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Register writes
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    step_nxt    = step_r;
    fmt_nxt     = fmt_r;
    src_st_nxt  = src_st_r;
    out_flt_nxt = out_flt_r;
    dst_st_nxt  = dst_st_r;
    if (cfg_wr) begin
      case (paddr[4:2])
        REG_STEP:    step_nxt    = pwdata[STEP_W-1:0];
        REG_IN_FMT:  fmt_nxt     = lir_fmt_t'(pwdata[1:0]);
        REG_SRC_ST:  src_st_nxt  = pwdata[0];
        REG_OUT_FLT: out_flt_nxt = pwdata[0];
        REG_DST_ST:  dst_st_nxt  = pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[4:2])
      REG_STEP:    prdata = DATA_W'(step_r);
      REG_IN_FMT:  prdata = DATA_W'(fmt_r);
      REG_SRC_ST:  prdata = DATA_W'(src_st_r);
      REG_OUT_FLT: prdata = DATA_W'(out_flt_r);
      REG_DST_ST:  prdata = DATA_W'(dst_st_r);
      default:     prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // Control state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      phase_r     <= '0;
      primed_r    <= 1'b0;
      step_r      <= STEP_RESET;
      fmt_r       <= FMT_F32;
      src_st_r    <= 1'b1;
      out_flt_r   <= 1'b1;
      dst_st_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      phase_r     <= phase_nxt;
      primed_r    <= primed_nxt;
      step_r      <= step_nxt;
      fmt_r       <= fmt_nxt;
      src_st_r    <= src_st_nxt;
      out_flt_r   <= out_flt_nxt;
      dst_st_r    <= dst_st_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_left_r  <= out_left_nxt;
    out_right_r <= out_right_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_left_out    = out_left_r;
  assign out_right_out   = out_right_r;
  assign out_last_of_run = out_last_r;

  // Checks
  `LIR_ASSERT_IMP(a_cmd_lanes_idle, (lane_cmd.dec || lane_cmd.emit), (!l_busy && !r_busy))
  `LIR_ASSERT_IMP(a_out_no_overwrite, out_load, (!out_valid_r || out_ready))
  `LIR_ASSERT_IMP(a_emit_frac_only, lane_cmd.emit, (phase_nxt[PH_W-1:PHASE_FRAC_BITS] == '0))
  `LIR_ASSERT_NXT(a_phase_bound, 1'b1, (phase_r[PH_W-1] == 1'b0))

endmodule

// ----- rtl/lir_lane.sv -----
// One channel of the resampler: serial decode of float32 input, bit-serial interpolation
// multiply and serial normalize for float encoding. Depends on lir_pkg.
module lir_lane
  import lir_pkg::*;
#(
  parameter int PHASE_FRAC_BITS = PHASE_FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lir_cfg_t                   cfg,
  input  lir_cmd_t                   cmd,
  input  logic [DATA_W-1:0]          raw,
  input  logic [PHASE_FRAC_BITS-1:0] frac,
  output logic                       busy,
  output logic [DATA_W-1:0]          res
);

  localparam int MCNT_W = $clog2(PHASE_FRAC_BITS + 1);

  typedef enum logic [7:0] {
    L_IDLE = 8'b0000_0001,
    L_DEC  = 8'b0000_0010,
    L_MUL  = 8'b0000_0100,
    L_ADD  = 8'b0000_1000,
    L_ABS  = 8'b0001_0000,
    L_SCL  = 8'b0010_0000,
    L_NORM = 8'b0100_0000,
    L_PACK = 8'b1000_0000
  } lane_st_t;

  lane_st_t                   st_r, st_nxt;
  logic [DATA_W-1:0]          cur_r, cur_nxt;
  logic [DATA_W-1:0]          prev_r, prev_nxt;
  logic [DATA_W-1:0]          sh_r, sh_nxt;      // shared shift register
  logic [4:0]                 cnt_r, cnt_nxt;    // decode / normalize count
  logic                       left_r, left_nxt;
  logic                       neg_r, neg_nxt;
  logic [DATA_W:0]            d_r, d_nxt;        // cur - prev, 33 bits signed
  logic [DATA_W:0]            acc_r, acc_nxt;
  logic [PHASE_FRAC_BITS-1:0] frac_r, frac_nxt;
  logic [MCNT_W-1:0]          mcnt_r, mcnt_nxt;
  logic [DATA_W-1:0]          res_r, res_nxt;

  // Float input fields
  logic        f_sign;
  logic [7:0]  f_exp;
  logic [22:0] f_man;
  assign f_sign = raw[31];
  assign f_exp  = raw[30:23];
  assign f_man  = raw[22:0];

  // Multiply step: add d when the frac bit is set, then arithmetic shift
  logic [DATA_W:0]   addend;
  logic [DATA_W+1:0] sum34;
  assign addend = frac_r[0] ? d_r : '0;
  assign sum34  = {acc_r[DATA_W], acc_r} + {addend[DATA_W], addend};

  // Int16 scale: min(|y|, 1.0) * 32767 >> 24
  logic [24:0] magc;
  logic [39:0] prod;
  assign magc = (sh_r > Q_ONE) ? Q_ONE[24:0] : sh_r[24:0];
  assign prod = {magc, 15'd0} - {15'd0, magc};

  // Float pack: round to nearest even on the normalized word
  logic        rnd;
  logic [24:0] mant25;
  logic [7:0]  exp_out;
  assign rnd     = sh_r[7] & ((|sh_r[6:0]) | sh_r[8]);
  assign mant25  = {1'b0, sh_r[31:8]} + 25'(rnd);
  assign exp_out = {3'd0, 5'd31 - cnt_r} + F_EXP_BIAS_OUT + {7'd0, mant25[24]};

  // Sequencer
  always_comb begin
    st_nxt   = st_r;
    cur_nxt  = cur_r;
    prev_nxt = prev_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    left_nxt = left_r;
    neg_nxt  = neg_r;
    d_nxt    = d_r;
    acc_nxt  = acc_r;
    frac_nxt = frac_r;
    mcnt_nxt = mcnt_r;
    res_nxt  = res_r;
    case (st_r)
      L_IDLE: begin
        if (cmd.commit) begin
          prev_nxt = cur_r;
        end
        if (cmd.emit) begin
          d_nxt    = {cur_r[DATA_W-1], cur_r} - {prev_r[DATA_W-1], prev_r};
          acc_nxt  = '0;
          frac_nxt = frac;
          mcnt_nxt = MCNT_W'(PHASE_FRAC_BITS);
          st_nxt   = L_MUL;
        end
        if (cmd.dec) begin
          case (cfg.input_format)
            FMT_INT16: cur_nxt = {{7{raw[15]}}, raw[15:0], 9'd0};
            FMT_INT24: cur_nxt = {{7{raw[23]}}, raw[23:0], 1'b0};
            FMT_INT32: cur_nxt = {{7{raw[31]}}, raw[31:7]};
            default: begin
              // float32: NaN and subnormals read as zero
              if (f_exp == 8'd0 || (f_exp == 8'hFF && f_man != '0)) begin
                cur_nxt = '0;
              end else if (f_exp >= F_EXP_SAT) begin
                cur_nxt = f_sign ? Q_NEG_SAT : Q_POS_SAT;
              end else begin
                sh_nxt  = {8'd0, 1'b1, f_man};
                neg_nxt = f_sign;
                if (f_exp >= F_EXP_UNIT) begin
                  left_nxt = 1'b1;
                  cnt_nxt  = 5'(f_exp - F_EXP_UNIT);
                end else if (f_exp < F_EXP_FLUSH) begin
                  left_nxt = 1'b0;
                  cnt_nxt  = DEC_MAX_SHIFT;
                end else begin
                  left_nxt = 1'b0;
                  cnt_nxt  = 5'(F_EXP_UNIT - f_exp);
                end
                st_nxt = L_DEC;
              end
            end
          endcase
        end
      end
      // one bit of alignment shift per cycle
      L_DEC: begin
        if (cnt_r == '0) begin
          cur_nxt = neg_r ? (32'd0 - sh_r) : sh_r;
          st_nxt  = L_IDLE;
        end else begin
          sh_nxt  = left_r ? {sh_r[30:0], 1'b0} : {1'b0, sh_r[31:1]};
          cnt_nxt = cnt_r - 5'd1;
        end
      end
      // one frac bit per cycle, LSB first; shifted-out bits give floor
      L_MUL: begin
        acc_nxt  = sum34[DATA_W+1:1];
        frac_nxt = frac_r >> 1;
        mcnt_nxt = mcnt_r - MCNT_W'(1);
        if (mcnt_r == MCNT_W'(1)) begin
          st_nxt = L_ADD;
        end
      end
      L_ADD: begin
        sh_nxt = prev_r + acc_r[DATA_W-1:0];
        st_nxt = L_ABS;
      end
      // sign and magnitude
      L_ABS: begin
        neg_nxt = sh_r[31];
        sh_nxt  = sh_r[31] ? (32'd0 - sh_r) : sh_r;
        cnt_nxt = '0;
        if (!cfg.output_float) begin
          st_nxt = L_SCL;
        end else if (sh_r == '0) begin
          res_nxt = '0;
          st_nxt  = L_IDLE;
        end else begin
          st_nxt = L_NORM;
        end
      end
      L_SCL: begin
        sh_nxt = 32'(prod[39:24]);
        st_nxt = L_PACK;
      end
      // shift left until the leading one reaches the top
      L_NORM: begin
        if (sh_r[31]) begin
          st_nxt = L_PACK;
        end else begin
          sh_nxt  = {sh_r[30:0], 1'b0};
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      L_PACK: begin
        if (cfg.output_float) begin
          res_nxt = {neg_r, exp_out, mant25[22:0]};
        end else begin
          res_nxt = neg_r ? (32'd0 - sh_r) : sh_r;
        end
        st_nxt = L_IDLE;
      end
      default: st_nxt = L_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= L_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    prev_r <= prev_nxt;
    sh_r   <= sh_nxt;
    cnt_r  <= cnt_nxt;
    left_r <= left_nxt;
    neg_r  <= neg_nxt;
    d_r    <= d_nxt;
    acc_r  <= acc_nxt;
    frac_r <= frac_nxt;
    mcnt_r <= mcnt_nxt;
    res_r  <= res_nxt;
  end

  assign busy = (st_r != L_IDLE);
  assign res  = res_r;

endmodule
